FILE: rtl/core/tepdr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch event decoder package
// Shared types, event codes and sizes for the press/drag/release decoder.
// ----------------------------------------------------------------------------
package tepdr_pkg;

	// Event fields
	localparam int TYPE_W  = 5;
	localparam int CODE_W  = 10;
	localparam int VALUE_W = 32;
	localparam int POS_W   = 16;
	localparam int KIND_W  = 2;

	localparam logic [TYPE_W-1:0] TYPE_SYNC = 5'd0;
	localparam logic [TYPE_W-1:0] TYPE_KEY  = 5'd1;
	localparam logic [TYPE_W-1:0] TYPE_AXIS = 5'd3;

	localparam logic [CODE_W-1:0] CODE_TOUCH  = 10'd330;
	localparam logic [CODE_W-1:0] CODE_AXIS_X = 10'd0;
	localparam logic [CODE_W-1:0] CODE_AXIS_Y = 10'd1;
	localparam logic [CODE_W-1:0] CODE_REPORT = 10'd0;

	localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DRAG    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_DISP_WIDTH    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DISP_HEIGHT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROTATION_MODE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DRAG_ENABLE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_AXIS_MIN_X    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_AXIS_MIN_Y    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_AXIS_SPAN_X   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_AXIS_SPAN_Y   = 3'd7;

	localparam logic [1:0] ROT_NONE = 2'd0;
	localparam logic [1:0] ROT_90   = 2'd1;
	localparam logic [1:0] ROT_180  = 2'd2;
	localparam logic [1:0] ROT_270  = 2'd3;

	localparam int SPAN_W = 31;
	localparam int DIFF_W = VALUE_W + 1;
	localparam int MAG_W  = VALUE_W;
	localparam int PROD_W = MAG_W + POS_W;

	// Two quotient bits are produced per divider cycle.
	localparam int DIV_STEPS = PROD_W / 2;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [POS_W-1:0]  disp_width;
		logic [POS_W-1:0]  disp_height;
		logic [1:0]        rotation_mode;
		logic              drag_enable;
		logic [VALUE_W-1:0] axis_min_x;
		logic [VALUE_W-1:0] axis_min_y;
		logic [SPAN_W-1:0] axis_span_x;
		logic [SPAN_W-1:0] axis_span_y;
	} cfg_t;

	typedef enum logic [2:0] {
		OP_PRESS,
		OP_RELEASE,
		OP_AXIS_X,
		OP_AXIS_Y,
		OP_SYNC
	} op_kind_t;

	typedef struct packed {
		op_kind_t          kind;
		logic [VALUE_W-1:0] value;
	} op_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_ABS,
		BK_MUL,
		BK_DIV,
		BK_DONE
	} bk_state_t;

endpackage

FILE: rtl/core/touch_event_press_drag_release_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch event press/drag/release decoder
// Turns kernel-style input events into PRESS, DRAG and RELEASE touch reports.
// ----------------------------------------------------------------------------
// Events are taken through a queue-like input and at most one report comes out
// per sync event. Ignored events cost one input transfer and nothing more. The
// front end holds up to four decoded operations, so input is taken while the
// back end works. In the back end a key or sync event is handled in the idle
// state, while a positive X or Y event runs through the difference, the
// magnitude, the 32x16 multiply, the divider that retires two quotient bits a
// cycle, and a final step that stores the result. A zero span skips these
// steps and stores a zero position. A report waits in an output register until
// it is popped; every sync event waits while that register is still occupied.
// Configuration writes are always ready and must happen only while the block
// is idle.
module touch_event_press_drag_release_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  logic [tepdr_pkg::TYPE_W-1:0]          ev_type,
	input  logic [tepdr_pkg::CODE_W-1:0]          event_code,
	input  logic signed [tepdr_pkg::VALUE_W-1:0]  event_value,
	output logic                                  empty,
	input  logic                                  pop,
	output logic [tepdr_pkg::POS_W-1:0]           pos_x,
	output logic [tepdr_pkg::POS_W-1:0]           pos_y,
	output logic [tepdr_pkg::KIND_W-1:0]          touch_kind,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [tepdr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tepdr_pkg::VALUE_W-1:0]         cfg_data
);
	import tepdr_pkg::*;

	cfg_t cfg_q;
	op_t  op;
	logic op_valid;
	logic op_pop;
	logic res_valid;

	assign cfg_ready = 1'b1;
	assign empty     = !res_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_DISP_WIDTH:    cfg_q.disp_width    <= cfg_data[POS_W-1:0];
				CFG_DISP_HEIGHT:   cfg_q.disp_height   <= cfg_data[POS_W-1:0];
				CFG_ROTATION_MODE: cfg_q.rotation_mode <= cfg_data[1:0];
				CFG_DRAG_ENABLE:   cfg_q.drag_enable   <= cfg_data[0];
				CFG_AXIS_MIN_X:    cfg_q.axis_min_x    <= cfg_data;
				CFG_AXIS_MIN_Y:    cfg_q.axis_min_y    <= cfg_data;
				CFG_AXIS_SPAN_X:   cfg_q.axis_span_x   <= cfg_data[SPAN_W-1:0];
				CFG_AXIS_SPAN_Y:   cfg_q.axis_span_y   <= cfg_data[SPAN_W-1:0];
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	tepdr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.ev_type     (ev_type),
		.event_code  (event_code),
		.event_value (event_value),
		.op_valid    (op_valid),
		.op_pop      (op_pop),
		.op          (op)
	);

	tepdr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.op_valid   (op_valid),
		.op         (op),
		.op_pop     (op_pop),
		.res_valid  (res_valid),
		.res_pop    (pop),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.touch_kind (touch_kind)
	);

endmodule

FILE: rtl/core/tepdr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch event decoder front end
// Accepts raw events, drops the ones that change nothing and queues the rest
// as decoded operations for the back end.
// ----------------------------------------------------------------------------
module tepdr_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [tepdr_pkg::TYPE_W-1:0]      ev_type,
	input  logic [tepdr_pkg::CODE_W-1:0]      event_code,
	input  logic signed [tepdr_pkg::VALUE_W-1:0] event_value,
	output logic                              op_valid,
	input  logic                              op_pop,
	output tepdr_pkg::op_t                    op
);
	import tepdr_pkg::*;

	op_t               queue_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	op_t  dec_op;
	logic dec_keep;
	logic accept;
	logic wr_en;
	logic rd_en;
	logic value_pos;

	assign value_pos = !event_value[VALUE_W-1] && (event_value != '0);

	always_comb begin
		dec_op.value = event_value;
		dec_op.kind  = OP_SYNC;
		dec_keep     = 1'b0;
		priority if (ev_type == TYPE_KEY && event_code == CODE_TOUCH
				&& event_value == VALUE_W'(1)) begin
			dec_op.kind = OP_PRESS;
			dec_keep    = 1'b1;
		end else if (ev_type == TYPE_KEY && event_code == CODE_TOUCH
				&& event_value == '0) begin
			dec_op.kind = OP_RELEASE;
			dec_keep    = 1'b1;
		end else if (ev_type == TYPE_AXIS && event_code == CODE_AXIS_X && value_pos) begin
			dec_op.kind = OP_AXIS_X;
			dec_keep    = 1'b1;
		end else if (ev_type == TYPE_AXIS && event_code == CODE_AXIS_Y && value_pos) begin
			dec_op.kind = OP_AXIS_Y;
			dec_keep    = 1'b1;
		end else if (ev_type == TYPE_SYNC && event_code == CODE_REPORT) begin
			dec_op.kind = OP_SYNC;
			dec_keep    = 1'b1;
		end
	end

	assign full     = (cnt_q == QCNT_W'(QDEPTH));
	assign accept   = push && !full;
	assign wr_en    = accept && dec_keep;
	assign op_valid = (cnt_q != '0);
	assign rd_en    = op_pop && op_valid;
	assign op       = queue_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (!wr_en && rd_en) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			queue_q[wr_ptr_q] <= dec_op;
		end
	end

endmodule

FILE: rtl/core/tepdr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch event decoder back end
// Executes queued operations: touch state updates, axis scaling through a
// shared multiplier and a radix-4 restoring divider, and report generation.
// ----------------------------------------------------------------------------
module tepdr_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tepdr_pkg::cfg_t               cfg,
	input  logic                          op_valid,
	input  tepdr_pkg::op_t                op,
	output logic                          op_pop,
	output logic                          res_valid,
	input  logic                          res_pop,
	output logic [tepdr_pkg::POS_W-1:0]   pos_x,
	output logic [tepdr_pkg::POS_W-1:0]   pos_y,
	output logic [tepdr_pkg::KIND_W-1:0]  touch_kind
);
	import tepdr_pkg::*;

	bk_state_t state_q, state_d;

	logic [VALUE_W-1:0] scaled_x_q, scaled_y_q;
	logic [POS_W-1:0]   held_x_q, held_y_q;
	logic               touching_q, flipped_q, moved_q, press_sent_q;

	logic               out_valid_q;
	logic [POS_W-1:0]   out_x_q, out_y_q;
	logic [KIND_W-1:0]  out_kind_q;

	logic               axis_y_q;
	logic [DIFF_W-1:0]  diff_q;
	logic               neg_q;
	logic [MAG_W-1:0]   mag_q;
	logic [PROD_W-1:0]  dvd_q;
	logic [SPAN_W-1:0]  rem_q;
	logic [STEP_W-1:0]  step_q;

	logic               out_free;
	logic               sync_go;
	logic               axis_go;
	logic               axis_zero;
	logic [SPAN_W-1:0]  span_sel;
	logic [POS_W-1:0]   size_sel;
	logic [POS_W-1:0]   rot_x, rot_y, new_hx, new_hy;
	logic               emit;
	logic [KIND_W-1:0]  emit_kind;
	logic [SPAN_W:0]    step1, step2;
	logic [MAG_W-1:0]   quot;

	function automatic logic [SPAN_W:0] div_step(input logic [SPAN_W-1:0] rem,
			input logic b, input logic [SPAN_W-1:0] dvs);
		logic [SPAN_W:0] trial;
		trial = {rem, b};
		if (trial >= {1'b0, dvs}) begin
			div_step = {1'b1, SPAN_W'(trial - {1'b0, dvs})};
		end else begin
			div_step = {1'b0, trial[SPAN_W-1:0]};
		end
	endfunction

	assign span_sel = axis_y_q ? cfg.axis_span_y : cfg.axis_span_x;
	assign size_sel = axis_y_q ? cfg.disp_height : cfg.disp_width;
	assign out_free = !out_valid_q || res_pop;

	assign res_valid  = out_valid_q;
	assign pos_x      = out_x_q;
	assign pos_y      = out_y_q;
	assign touch_kind = out_kind_q;

	// Rotation of the scaled position; only the low 16 bits matter.
	always_comb begin
		unique case (cfg.rotation_mode)
			ROT_90: begin
				rot_x = scaled_y_q[POS_W-1:0];
				rot_y = cfg.disp_width - POS_W'(1) - scaled_x_q[POS_W-1:0];
			end
			ROT_180: begin
				rot_x = cfg.disp_width - POS_W'(1) - scaled_x_q[POS_W-1:0];
				rot_y = cfg.disp_height - POS_W'(1) - scaled_y_q[POS_W-1:0];
			end
			ROT_270: begin
				rot_x = cfg.disp_height - POS_W'(1) - scaled_y_q[POS_W-1:0];
				rot_y = scaled_x_q[POS_W-1:0];
			end
			default: begin
				rot_x = scaled_x_q[POS_W-1:0];
				rot_y = scaled_y_q[POS_W-1:0];
			end
		endcase
		new_hx = moved_q ? rot_x : held_x_q;
		new_hy = moved_q ? rot_y : held_y_q;
	end

	always_comb begin
		emit      = 1'b0;
		emit_kind = KIND_PRESS;
		if (touching_q && (moved_q || flipped_q)) begin
			if (!press_sent_q) begin
				emit = 1'b1;
			end else if (cfg.drag_enable && moved_q) begin
				emit      = 1'b1;
				emit_kind = KIND_DRAG;
			end
		end else if (!touching_q && flipped_q) begin
			emit      = 1'b1;
			emit_kind = KIND_RELEASE;
		end
	end

	assign step1 = div_step(rem_q, dvd_q[PROD_W-1], span_sel);
	assign step2 = div_step(step1[SPAN_W-1:0], dvd_q[PROD_W-2], span_sel);
	assign quot  = dvd_q[MAG_W-1:0];

	always_comb begin
		state_d   = state_q;
		op_pop    = 1'b0;
		sync_go   = 1'b0;
		axis_go   = 1'b0;
		axis_zero = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (op_valid) begin
					unique case (op.kind)
						OP_PRESS, OP_RELEASE: begin
							op_pop = 1'b1;
						end
						OP_AXIS_X, OP_AXIS_Y: begin
							op_pop = 1'b1;
							if ((op.kind == OP_AXIS_X ? cfg.axis_span_x : cfg.axis_span_y)
									== '0) begin
								axis_zero = 1'b1;
							end else begin
								axis_go = 1'b1;
								state_d = BK_ABS;
							end
						end
						OP_SYNC: begin
							if (out_free) begin
								op_pop  = 1'b1;
								sync_go = 1'b1;
							end
						end
						default: begin
							op_pop = 1'b1;
						end
					endcase
				end
			end
			BK_ABS:  state_d = BK_MUL;
			BK_MUL:  state_d = BK_DIV;
			BK_DIV: begin
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					state_d = BK_DONE;
				end
			end
			BK_DONE: state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_IDLE;
			scaled_x_q   <= '0;
			scaled_y_q   <= '0;
			held_x_q     <= '0;
			held_y_q     <= '0;
			touching_q   <= 1'b0;
			flipped_q    <= 1'b0;
			moved_q      <= 1'b0;
			press_sent_q <= 1'b0;
			out_valid_q  <= 1'b0;
			step_q       <= '0;
		end else begin
			state_q <= state_d;
			if (res_pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			if (op_pop && op.kind == OP_PRESS) begin
				touching_q   <= 1'b1;
				flipped_q    <= 1'b1;
				press_sent_q <= 1'b0;
			end
			if (op_pop && op.kind == OP_RELEASE) begin
				touching_q <= 1'b0;
				flipped_q  <= 1'b1;
			end
			if (axis_zero) begin
				moved_q <= 1'b1;
				if (op.kind == OP_AXIS_Y) begin
					scaled_y_q <= '0;
				end else begin
					scaled_x_q <= '0;
				end
			end
			if (sync_go) begin
				held_x_q  <= new_hx;
				held_y_q  <= new_hy;
				flipped_q <= 1'b0;
				moved_q   <= 1'b0;
				if (emit && emit_kind == KIND_PRESS) begin
					press_sent_q <= 1'b1;
				end
				if (emit) begin
					out_valid_q <= 1'b1;
				end
			end
			if (state_q == BK_MUL) begin
				step_q <= '0;
			end else if (state_q == BK_DIV) begin
				step_q <= step_q + STEP_W'(1);
			end
			if (state_q == BK_DONE) begin
				moved_q <= 1'b1;
				if (axis_y_q) begin
					scaled_y_q <= neg_q ? MAG_W'(-quot) : quot;
				end else begin
					scaled_x_q <= neg_q ? MAG_W'(-quot) : quot;
				end
			end
		end
	end

	// Datapath registers of the scaling unit and the report register.
	always_ff @(posedge clk) begin
		if (axis_go) begin
			axis_y_q <= (op.kind == OP_AXIS_Y);
			diff_q   <= {op.value[VALUE_W-1], op.value}
				- {(op.kind == OP_AXIS_Y ? cfg.axis_min_y[VALUE_W-1] : cfg.axis_min_x[VALUE_W-1]),
				   (op.kind == OP_AXIS_Y ? cfg.axis_min_y : cfg.axis_min_x)};
		end
		if (state_q == BK_ABS) begin
			neg_q <= diff_q[DIFF_W-1];
			mag_q <= diff_q[DIFF_W-1] ? MAG_W'(-diff_q) : diff_q[MAG_W-1:0];
		end
		if (state_q == BK_MUL) begin
			dvd_q <= PROD_W'(mag_q) * PROD_W'(size_sel);
			rem_q <= '0;
		end
		if (state_q == BK_DIV) begin
			// Dividend bits shift out at the top, quotient bits shift in below.
			dvd_q <= {dvd_q[PROD_W-3:0], step1[SPAN_W], step2[SPAN_W]};
			rem_q <= step2[SPAN_W-1:0];
		end
		if (sync_go && emit) begin
			out_x_q    <= new_hx;
			out_y_q    <= new_hy;
			out_kind_q <= emit_kind;
		end
	end

endmodule

FILE: rtl/core/tepdr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch event decoder port checker
// Port-level checks on reset behavior and the report channel.
// ----------------------------------------------------------------------------
module tepdr_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 full,
	input logic                                 empty,
	input logic                                 pop,
	input logic [tepdr_pkg::POS_W-1:0]          pos_x,
	input logic [tepdr_pkg::POS_W-1:0]          pos_y,
	input logic [tepdr_pkg::KIND_W-1:0]         touch_kind
);
	import tepdr_pkg::*;

	// After an edge with reset held no report is offered and input is open.
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> (empty && !full))
		else $error("report pending or input full after reset");

	// Only press, drag and release are ever reported.
	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (touch_kind == KIND_PRESS || touch_kind == KIND_DRAG
			|| touch_kind == KIND_RELEASE))
		else $error("illegal touch kind reported");

	// A report that is not taken stays unchanged.
	a_report_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(pos_x) && $stable(pos_y)
			&& $stable(touch_kind)))
		else $error("report changed before its transfer");

endmodule

bind touch_event_press_drag_release_core tepdr_checker u_tepdr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.full       (full),
	.empty      (empty),
	.pop        (pop),
	.pos_x      (pos_x),
	.pos_y      (pos_y),
	.touch_kind (touch_kind)
);

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch event decoder testbench
// Drives key, axis and sync events through the queue-style input and checks
// every PRESS, DRAG and RELEASE report against a cycle-free predictor that
// follows each input and configuration transfer. A directed part covers the
// field extremes and corner cases, then random phases change the settings
// and the idle pattern on both sides.
// ----------------------------------------------------------------------------
module testbench;
	import tepdr_pkg::*;

	localparam logic signed [VALUE_W-1:0] KEY_DOWN = 32'sd1;
	localparam logic signed [VALUE_W-1:0] KEY_UP   = 32'sd0;
	localparam logic signed [VALUE_W-1:0] KEY_BAD  = 32'sd2;
	localparam logic signed [VALUE_W-1:0] VAL_MAX  = 32'sh7FFF_FFFF;
	localparam logic signed [VALUE_W-1:0] VAL_MIN  = 32'sh8000_0000;

	localparam logic [TYPE_W-1:0] TYPE_UNUSED_LO = 5'd2;
	localparam logic [TYPE_W-1:0] TYPE_UNUSED_HI = 5'd31;
	localparam logic [CODE_W-1:0] CODE_OTHER_KEY  = 10'd331;
	localparam logic [CODE_W-1:0] CODE_AXIS_OTHER = 10'd2;
	localparam logic [CODE_W-1:0] CODE_TOP        = 10'd1023;

	localparam int SETTLE_CYCLES = 200;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 95;

	typedef struct packed {
		logic [POS_W-1:0]  x;
		logic [POS_W-1:0]  y;
		logic [KIND_W-1:0] kind;
	} report_t;

	logic                       clk;
	logic                       arst_n = 1'b0;
	logic                       push = 1'b0;
	logic                       full;
	logic [TYPE_W-1:0]          ev_type = '0;
	logic [CODE_W-1:0]          event_code = '0;
	logic signed [VALUE_W-1:0]  event_value = '0;
	logic                       empty;
	logic                       pop = 1'b0;
	logic [POS_W-1:0]           pos_x;
	logic [POS_W-1:0]           pos_y;
	logic [KIND_W-1:0]          touch_kind;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index = '0;
	logic [VALUE_W-1:0]         cfg_data = '0;

	// Predictor state, updated from the observed transfers.
	cfg_t         cur_cfg = '0;
	logic [31:0]  pix_x = '0;
	logic [31:0]  pix_y = '0;
	logic [15:0]  shown_x = '0;
	logic [15:0]  shown_y = '0;
	bit           finger_down = 1'b0;
	bit           key_changed = 1'b0;
	bit           coord_changed = 1'b0;
	bit           press_done = 1'b0;

	report_t      pending_reports[$];
	int           error_count = 0;
	int           sender_pct = 0;
	int           stall_pct = 0;

	touch_event_press_drag_release_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.ev_type    (ev_type),
		.event_code (event_code),
		.event_value(event_value),
		.empty      (empty),
		.pop        (pop),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.touch_kind (touch_kind),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("touch_event_press_drag_release_core test failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic logic [31:0] to_screen(input logic signed [31:0] raw,
			input logic signed [31:0] lo, input logic [30:0] span,
			input logic [15:0] size);
		longint prod;
		longint quo;
		if (span == '0)
			return '0;
		prod = longint'(size) * (longint'(raw) - longint'(lo));
		// Signed division truncates toward zero; only the low word is kept.
		quo = prod / longint'(span);
		return quo[31:0];
	endfunction

	function automatic void set_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [VALUE_W-1:0] data);
		case (idx)
			CFG_DISP_WIDTH:    cur_cfg.disp_width    = data[POS_W-1:0];
			CFG_DISP_HEIGHT:   cur_cfg.disp_height   = data[POS_W-1:0];
			CFG_ROTATION_MODE: cur_cfg.rotation_mode = data[1:0];
			CFG_DRAG_ENABLE:   cur_cfg.drag_enable   = data[0];
			CFG_AXIS_MIN_X:    cur_cfg.axis_min_x    = data;
			CFG_AXIS_MIN_Y:    cur_cfg.axis_min_y    = data;
			CFG_AXIS_SPAN_X:   cur_cfg.axis_span_x   = data[SPAN_W-1:0];
			default:           cur_cfg.axis_span_y   = data[SPAN_W-1:0];
		endcase
	endfunction

	function automatic bit decode_event(input logic [TYPE_W-1:0] t,
			input logic [CODE_W-1:0] c, input logic signed [VALUE_W-1:0] v,
			output report_t rep);
		logic [31:0] rx;
		logic [31:0] ry;
		logic [31:0] w;
		logic [31:0] h;
		bit emit;
		emit = 1'b0;
		rep = '0;
		if (t == TYPE_KEY) begin
			if (c == CODE_TOUCH && v == KEY_DOWN) begin
				finger_down = 1'b1;
				key_changed = 1'b1;
				press_done = 1'b0;
			end else if (c == CODE_TOUCH && v == KEY_UP) begin
				finger_down = 1'b0;
				key_changed = 1'b1;
			end
		end else if (t == TYPE_AXIS) begin
			if (c == CODE_AXIS_X && v > 0) begin
				pix_x = to_screen(v, cur_cfg.axis_min_x, cur_cfg.axis_span_x,
					cur_cfg.disp_width);
				coord_changed = 1'b1;
			end else if (c == CODE_AXIS_Y && v > 0) begin
				pix_y = to_screen(v, cur_cfg.axis_min_y, cur_cfg.axis_span_y,
					cur_cfg.disp_height);
				coord_changed = 1'b1;
			end
		end else if (t == TYPE_SYNC && c == CODE_REPORT) begin
			if (coord_changed) begin
				w = {16'd0, cur_cfg.disp_width};
				h = {16'd0, cur_cfg.disp_height};
				case (cur_cfg.rotation_mode)
					ROT_90: begin
						rx = pix_y;
						ry = w - 32'd1 - pix_x;
					end
					ROT_180: begin
						rx = w - 32'd1 - pix_x;
						ry = h - 32'd1 - pix_y;
					end
					ROT_270: begin
						rx = h - 32'd1 - pix_y;
						ry = pix_x;
					end
					default: begin
						rx = pix_x;
						ry = pix_y;
					end
				endcase
				shown_x = rx[15:0];
				shown_y = ry[15:0];
			end
			if (finger_down && (coord_changed || key_changed)) begin
				if (!press_done) begin
					rep.kind = KIND_PRESS;
					press_done = 1'b1;
					emit = 1'b1;
				end else if (cur_cfg.drag_enable && coord_changed) begin
					rep.kind = KIND_DRAG;
					emit = 1'b1;
				end
			end else if (!finger_down && key_changed) begin
				rep.kind = KIND_RELEASE;
				emit = 1'b1;
			end
			key_changed = 1'b0;
			coord_changed = 1'b0;
		end
		rep.x = shown_x;
		rep.y = shown_y;
		return emit;
	endfunction

	// Results are checked before the input of the same edge is predicted; a
	// report can never leave on the edge that brings in its sync event.
	always @(posedge clk) begin : monitor
		report_t got;
		report_t want;
		report_t rep;
		if (arst_n) begin
			if (pop && !empty) begin
				got = '{x: pos_x, y: pos_y, kind: touch_kind};
				if (pending_reports.size() == 0) begin
					if (error_count < 10)
						$display("unexpected report: x=%0d y=%0d kind=%0d",
							got.x, got.y, got.kind);
					error_count++;
				end else begin
					want = pending_reports.pop_front();
					if (got.x !== want.x || got.y !== want.y || got.kind !== want.kind) begin
						if (error_count < 10)
							$display("mismatch: exp x=%0d y=%0d kind=%0d got x=%0d y=%0d kind=%0d",
								want.x, want.y, want.kind, got.x, got.y, got.kind);
						error_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				set_register(cfg_index, cfg_data);
			if (push && !full) begin
				if (decode_event(ev_type, event_code, event_value, rep))
					pending_reports.push_back(rep);
			end
		end
	end

	always @(posedge clk)
		pop <= ($urandom_range(99) >= stall_pct);

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------
	// Leaves push high after the transfer so back-to-back events never drop it.
	task automatic send_event(input logic [TYPE_W-1:0] t, input logic [CODE_W-1:0] c,
			input logic signed [VALUE_W-1:0] v);
		while ($urandom_range(99) < sender_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		ev_type <= t;
		event_code <= c;
		event_value <= v;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VALUE_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic load_config(input cfg_t c);
		write_reg(CFG_DISP_WIDTH, {16'd0, c.disp_width});
		write_reg(CFG_DISP_HEIGHT, {16'd0, c.disp_height});
		write_reg(CFG_ROTATION_MODE, {30'd0, c.rotation_mode});
		write_reg(CFG_DRAG_ENABLE, {31'd0, c.drag_enable});
		write_reg(CFG_AXIS_MIN_X, c.axis_min_x);
		write_reg(CFG_AXIS_MIN_Y, c.axis_min_y);
		write_reg(CFG_AXIS_SPAN_X, {1'b0, c.axis_span_x});
		write_reg(CFG_AXIS_SPAN_Y, {1'b0, c.axis_span_y});
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_results_drained();
		push <= 1'b0;
		do
			@(posedge clk);
		while (pending_reports.size() != 0);
	endtask

	// Events that cause no report may still be in the divider once the last
	// report is out, so the block gets extra time before it is reconfigured.
	task automatic settle();
		wait_results_drained();
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	function automatic cfg_t make_config(input logic [15:0] w, input logic [15:0] h,
			input logic [1:0] rot, input logic drag, input logic [31:0] min_x,
			input logic [31:0] min_y, input logic [30:0] span_x, input logic [30:0] span_y);
		cfg_t c;
		c.disp_width = w;
		c.disp_height = h;
		c.rotation_mode = rot;
		c.drag_enable = drag;
		c.axis_min_x = min_x;
		c.axis_min_y = min_y;
		c.axis_span_x = span_x;
		c.axis_span_y = span_y;
		return c;
	endfunction

	function automatic logic [31:0] random_position(input logic [31:0] lo, input logic [30:0] span);
		longint pick;
		case ($urandom_range(9))
			0: return $urandom;
			1: return $urandom_range(1, 32'h7FFF_FFFF);
			2: return VAL_MAX;
			default: begin
				pick = longint'($signed(lo)) + longint'($urandom_range(0, span));
				if (pick < 1 || pick > 64'sh7FFF_FFFF)
					return $urandom_range(1, 1000);
				return pick[31:0];
			end
		endcase
	endfunction

	function automatic cfg_t random_config(input int phase);
		cfg_t c;
		c.disp_width = ($urandom_range(3) == 0) ? POS_W'($urandom)
			: POS_W'($urandom_range(1, 4096));
		c.disp_height = ($urandom_range(3) == 0) ? POS_W'($urandom)
			: POS_W'($urandom_range(1, 4096));
		c.rotation_mode = phase[1:0];
		c.drag_enable = 1'($urandom_range(1));
		c.axis_min_x = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 1000) - 500;
		c.axis_min_y = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 1000) - 500;
		c.axis_span_x = ($urandom_range(3) == 0) ? SPAN_W'($urandom_range(0, 32'h7FFF_FFFF))
			: SPAN_W'($urandom_range(1, 4095));
		c.axis_span_y = ($urandom_range(3) == 0) ? SPAN_W'($urandom_range(0, 32'h7FFF_FFFF))
			: SPAN_W'($urandom_range(1, 4095));
		return c;
	endfunction

	// Mostly touch gestures with random content, plus some raw noise.
	task automatic send_random_event();
		int sel;
		sel = $urandom_range(99);
		if (sel < 12)
			send_event(TYPE_KEY, CODE_TOUCH, KEY_DOWN);
		else if (sel < 22)
			send_event(TYPE_KEY, CODE_TOUCH, KEY_UP);
		else if (sel < 46)
			send_event(TYPE_AXIS, CODE_AXIS_X,
				random_position(cur_cfg.axis_min_x, cur_cfg.axis_span_x));
		else if (sel < 70)
			send_event(TYPE_AXIS, CODE_AXIS_Y,
				random_position(cur_cfg.axis_min_y, cur_cfg.axis_span_y));
		else if (sel < 90)
			send_event(TYPE_SYNC, CODE_REPORT, $urandom);
		else
			send_event(TYPE_W'($urandom_range(31)), CODE_W'($urandom_range(1023)), $urandom);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_touch_reports();
		load_config(make_config(16'd800, 16'd480, ROT_NONE, 1'b1, 32'd0, 32'd0,
			31'd4095, 31'd4095));
		send_event(TYPE_KEY, CODE_TOUCH, KEY_DOWN);
		send_event(TYPE_AXIS, CODE_AXIS_X, 32'sd2048);
		send_event(TYPE_AXIS, CODE_AXIS_Y, 32'sd1024);
		send_event(TYPE_SYNC, CODE_REPORT, 32'sd0);
		send_event(TYPE_AXIS, CODE_AXIS_X, VAL_MAX);
		send_event(TYPE_SYNC, CODE_REPORT, VAL_MIN);
		send_event(TYPE_SYNC, CODE_REPORT, 32'sd0);
		send_event(TYPE_KEY, CODE_TOUCH, KEY_UP);
		send_event(TYPE_SYNC, CODE_REPORT, 32'sd0);
	endtask

	task automatic test_ignored_events();
		send_event(TYPE_KEY, CODE_TOUCH, KEY_BAD);
		send_event(TYPE_KEY, CODE_OTHER_KEY, KEY_DOWN);
		send_event(TYPE_AXIS, CODE_AXIS_OTHER, 32'sd100);
		send_event(TYPE_AXIS, CODE_AXIS_X, 32'sd0);
		send_event(TYPE_AXIS, CODE_AXIS_Y, VAL_MIN);
		send_event(TYPE_UNUSED_LO, CODE_REPORT, 32'sd0);
		send_event(TYPE_UNUSED_HI, CODE_TOP, -32'sd1);
		send_event(TYPE_SYNC, CODE_TOP, 32'sd0);
		send_event(TYPE_SYNC, CODE_REPORT, 32'sd0);
	endtask

	// Below-minimum and oversized quotients, a zero span, and wrapping rotation.
	task automatic test_scaling_edges();
		settle();
		load_config(make_config(16'hFFFF, 16'd0, ROT_180, 1'b0, 32'd1000, VAL_MIN,
			31'd3, 31'd0));
		send_event(TYPE_KEY, CODE_TOUCH, KEY_DOWN);
		send_event(TYPE_AXIS, CODE_AXIS_X, 32'sd10);
		send_event(TYPE_AXIS, CODE_AXIS_Y, 32'sd5);
		send_event(TYPE_SYNC, CODE_REPORT, 32'sd0);
		send_event(TYPE_AXIS, CODE_AXIS_X, VAL_MAX);
		send_event(TYPE_SYNC, CODE_REPORT, 32'sd0);
		send_event(TYPE_KEY, CODE_TOUCH, KEY_UP);
		send_event(TYPE_SYNC, CODE_REPORT, 32'sd0);
	endtask

	task automatic test_random_phases();
		cfg_t c;
		for (int phase = 0; phase < PHASES; phase++) begin
			settle();
			if (phase == 0)
				c = make_config(16'hFFFF, 16'hFFFF, ROT_NONE, 1'b1, VAL_MIN, VAL_MAX,
					31'h7FFF_FFFF, 31'h7FFF_FFFF);
			else if (phase == 1)
				c = make_config(16'd0, 16'd0, ROT_90, 1'b0, 32'd0, 32'd0, 31'd0, 31'd0);
			else
				c = random_config(phase);
			load_config(c);
			case ((phase / 2) % 4)
				0: begin
					sender_pct = 0;
					stall_pct = 0;
				end
				1: begin
					sender_pct = 64;
					stall_pct = 0;
				end
				2: begin
					sender_pct = 0;
					stall_pct = 64;
				end
				default: begin
					sender_pct = 16;
					stall_pct = 16;
				end
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (phase == 3 && i == PHASE_ITEMS / 2)
					wait_results_drained();
				send_random_event();
			end
		end
	endtask

	initial begin
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_touch_reports();
		test_ignored_events();
		test_scaling_edges();
		test_random_phases();
		settle();
		if (pending_reports.size() != 0) begin
			$display("%0d expected reports never arrived", pending_reports.size());
			error_count++;
		end
		if (error_count == 0)
			$display("touch_event_press_drag_release_core test passed");
		else
			$display("touch_event_press_drag_release_core test failed");
		$finish;
	end

endmodule
